@@ design/hfdc_pkg.sv @@
package hfdc_pkg;

  // frame size limits
  localparam int unsigned MaxFrame = 128;
  localparam int unsigned MinFrame = 8;
  localparam int unsigned CountW   = 8;
  localparam logic [CountW-1:0] MaxCount = CountW'(MaxFrame);
  localparam logic [CountW-1:0] MinCount = CountW'(MinFrame);

  // configuration register defaults
  localparam logic [7:0] HeaderFirstRst  = 8'h54;
  localparam logic [7:0] HeaderSecondRst = 8'h47;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 1'b0,
    CFG_HEADER_SECOND = 1'b1
  } cfg_reg_e;

  // frame status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_HEADER   = 3'd2,
    ST_LENGTH   = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_BAD_HEX  = 3'd5,
    ST_TOO_LONG = 3'd6
  } status_e;

  // decoded character: bad flag and digit value
  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } digit_t;

  // strict hex digit decode
  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    d.bad = 1'b0;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

@@ design/hex_frame_deframer_checker.sv @@
// Decodes a received frame of ASCII hex characters, one character per transaction, into
// bytes, most significant digit first, and checks the frame when the character marked
// last_char arrives. One result follows for each decoded byte and one for the frame's
// last character (both in the same result when they coincide); frame_status is valid
// with frame_end. A character is taken into an input register, decoded and checked in
// one pass of logic, and the result lands in an output register, so the block takes
// one character per cycle; it holds off only while a result waits in the output
// register under out_stall_i. Write the header registers only while no frame is in
// progress.
module hex_frame_deframer_checker
  import hfdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // character channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         hex_char_i,
  input  logic               last_char_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         data_byte_o,
  output logic               byte_valid_o,
  output logic               frame_end_o,
  output logic [2:0]         frame_status_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic [7:0] hdr_first_q, hdr_second_q;

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;

  logic              nib_pend_q, nib_pend_d;
  logic              pend_bad_q, pend_bad_d;
  logic [3:0]        high_q, high_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        latest_q, latest_d;
  logic [7:0]        decl_len_q, decl_len_d;
  logic              hdr_err_q, hdr_err_d;
  logic              hex_err_q, hex_err_d;
  logic              ovf_q, ovf_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_bvalid_q, out_end_q;
  status_e    out_status_q;

  logic       advance, emit, have_byte;
  logic [7:0] new_byte;
  status_e    status;
  digit_t     dig;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data_i;
        CFG_HEADER_SECOND: hdr_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when the output register is free or drains
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_char_q <= hex_char_i;
      s1_last_q <= last_char_i;
    end
  end

  // digit pairing, frame tracking and end-of-frame check
  assign dig = hex_digit(s1_char_q);

  always_comb begin
    nib_pend_d = nib_pend_q;
    pend_bad_d = pend_bad_q;
    high_d     = high_q;
    count_d    = count_q;
    sum_d      = sum_q;
    latest_d   = latest_q;
    decl_len_d = decl_len_q;
    hdr_err_d  = hdr_err_q;
    hex_err_d  = hex_err_q;
    ovf_d      = ovf_q;
    have_byte  = 1'b0;
    new_byte   = {high_q, dig.val};
    status     = ST_OK;

    if (advance) begin
      if (!nib_pend_q) begin
        nib_pend_d = 1'b1;
        pend_bad_d = dig.bad;
        high_d     = dig.val;
      end else begin
        nib_pend_d = 1'b0;
        if (pend_bad_q || dig.bad) begin
          hex_err_d = 1'b1;
        end else if (!hex_err_q) begin
          if (count_q >= MaxCount) begin
            ovf_d = 1'b1;
          end else begin
            if (count_q == CountW'(0) && new_byte != hdr_first_q) hdr_err_d = 1'b1;
            if (count_q == CountW'(1) && new_byte != hdr_second_q) hdr_err_d = 1'b1;
            if (count_q == CountW'(2)) decl_len_d = new_byte;
            if (count_q != CountW'(0)) sum_d = sum_q + latest_q;
            latest_d  = new_byte;
            count_d   = count_q + CountW'(1);
            have_byte = 1'b1;
          end
        end
        pend_bad_d = 1'b0;
        high_d     = 4'd0;
      end

      if (s1_last_q) begin
        priority if (hex_err_d)                            status = ST_BAD_HEX;
        else if (ovf_d)                                    status = ST_TOO_LONG;
        else if (count_d < MinCount)                       status = ST_SHORT;
        else if (hdr_err_d)                                status = ST_HEADER;
        else if (8'(decl_len_d) != 8'(count_d - MinCount)) status = ST_LENGTH;
        else if (sum_d != latest_d)                        status = ST_CHECKSUM;
        else                                               status = ST_OK;
        nib_pend_d = 1'b0;
        pend_bad_d = 1'b0;
        high_d     = 4'd0;
        count_d    = '0;
        sum_d      = 8'd0;
        latest_d   = 8'd0;
        decl_len_d = 8'd0;
        hdr_err_d  = 1'b0;
        hex_err_d  = 1'b0;
        ovf_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_pend_q <= 1'b0;
      pend_bad_q <= 1'b0;
      high_q     <= 4'd0;
      count_q    <= '0;
      sum_q      <= 8'd0;
      latest_q   <= 8'd0;
      decl_len_q <= 8'd0;
      hdr_err_q  <= 1'b0;
      hex_err_q  <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      nib_pend_q <= nib_pend_d;
      pend_bad_q <= pend_bad_d;
      high_q     <= high_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      latest_q   <= latest_d;
      decl_len_q <= decl_len_d;
      hdr_err_q  <= hdr_err_d;
      hex_err_q  <= hex_err_d;
      ovf_q      <= ovf_d;
    end
  end

  // output register
  assign emit = advance && (have_byte || s1_last_q);

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q   <= have_byte ? new_byte : 8'd0;
      out_bvalid_q <= have_byte;
      out_end_q    <= s1_last_q;
      out_status_q <= status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_byte_q;
  assign byte_valid_o   = out_bvalid_q;
  assign frame_end_o    = out_end_q;
  assign frame_status_o = out_status_q;

`ifndef SYNTHESIS
  // a held result always carries a byte or a frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_bvalid_q || out_end_q))
    else $error("result with neither byte nor frame end");

  // status is only reported on the frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_end_q) |-> (out_status_q == ST_OK))
    else $error("status outside frame end");

  // byte count never passes the frame limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("byte count beyond frame limit");

  // overflow only once the frame is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == MaxCount))
    else $error("overflow with room left");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import hfdc_pkg::*;

  // one result transaction as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       ends;
    status_e    status;
  } deframe_res_t;

  // one row of the directed character table
  typedef struct packed {
    logic [7:0]   ch;
    logic         last;
    logic         typed;
    deframe_res_t want;
  } char_row_t;

  // kinds of random frames
  typedef enum {
    SHAPE_GOOD, SHAPE_HEADER, SHAPE_LENGTH, SHAPE_CHECKSUM, SHAPE_BAD_CHAR,
    SHAPE_ODD_TAIL, SHAPE_SHORT, SHAPE_NOISE, SHAPE_FULL, SHAPE_OVERSIZE
  } frame_shape_e;

  localparam deframe_res_t NoResult = '{8'h00, 1'b0, 1'b0, ST_OK};
  localparam int NumRows = 24;
  localparam int PhaseChars = 310;
  localparam int QuietLimit = 2000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         hex_char;
  logic               last_char;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         data_byte;
  logic               byte_valid;
  logic               frame_end;
  logic [2:0]         frame_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [7:0]         cfg_data;

  // typed expectation riding along with a directed character
  logic               row_typed;
  deframe_res_t       row_want;

  // predictor copy of configuration and frame state
  logic [7:0] hdr_first = HeaderFirstRst;
  logic [7:0] hdr_second = HeaderSecondRst;
  logic       pair_open = 1'b0;
  logic       first_bad = 1'b0;
  logic [3:0] high_dig = 4'd0;
  logic [7:0] byte_cnt = 8'd0;
  logic [7:0] sum_prior = 8'd0;
  logic [7:0] newest = 8'd0;
  logic [7:0] len_field = 8'd0;
  logic       hdr_bad = 1'b0;
  logic       bad_hex = 1'b0;
  logic       too_long = 1'b0;

  deframe_res_t deframe_q[$];
  logic [7:0]   frame_chars[$];
  char_row_t    char_rows[NumRows];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           stall_left = 0;
  logic         idle_on = 1'b0;

  hex_frame_deframer_checker dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .hex_char_i     (hex_char),
    .last_char_i    (last_char),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .data_byte_o    (data_byte),
    .byte_valid_o   (byte_valid),
    .frame_end_o    (frame_end),
    .frame_status_o (frame_status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // digit value of a character, 16 when it is not strict hex
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  // hex character for a digit, letters in random case
  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  // predict the result of one accepted character
  task automatic decode_char(input logic [7:0] ch, input logic last,
                             output deframe_res_t res, output logic made);
    logic [4:0] dv;
    logic [7:0] v;
    logic       got_byte;
    dv = hex_value(ch);
    v = 8'd0;
    got_byte = 1'b0;
    res = NoResult;
    if (!pair_open) begin
      pair_open = 1'b1;
      first_bad = dv[4];
      high_dig = dv[3:0];
    end else begin
      pair_open = 1'b0;
      if (first_bad || dv[4]) begin
        bad_hex = 1'b1;
      end else if (!bad_hex) begin
        v = {high_dig, dv[3:0]};
        if (byte_cnt >= MaxCount) begin
          too_long = 1'b1;
        end else begin
          if (byte_cnt == 8'd0 && v != hdr_first) hdr_bad = 1'b1;
          if (byte_cnt == 8'd1 && v != hdr_second) hdr_bad = 1'b1;
          if (byte_cnt == 8'd2) len_field = v;
          if (byte_cnt != 8'd0) sum_prior = sum_prior + newest;
          newest = v;
          byte_cnt = byte_cnt + 8'd1;
          got_byte = 1'b1;
        end
      end
      first_bad = 1'b0;
      high_dig = 4'd0;
    end
    res.data = got_byte ? v : 8'd0;
    res.has_byte = got_byte;
    res.ends = last;
    // frame verdict in precedence order, then start a fresh frame
    if (last) begin
      if (bad_hex) res.status = ST_BAD_HEX;
      else if (too_long) res.status = ST_TOO_LONG;
      else if (byte_cnt < MinCount) res.status = ST_SHORT;
      else if (hdr_bad) res.status = ST_HEADER;
      else if (len_field != 8'(byte_cnt - MinCount)) res.status = ST_LENGTH;
      else if (sum_prior != newest) res.status = ST_CHECKSUM;
      else res.status = ST_OK;
      pair_open = 1'b0;
      first_bad = 1'b0;
      high_dig = 4'd0;
      byte_cnt = 8'd0;
      sum_prior = 8'd0;
      newest = 8'd0;
      len_field = 8'd0;
      hdr_bad = 1'b0;
      bad_hex = 1'b0;
      too_long = 1'b0;
    end
    made = got_byte || last;
  endtask

  task automatic report_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // predict on accepted characters, check accepted results
  always @(posedge clk) begin : track_results
    deframe_res_t want;
    deframe_res_t got;
    logic         made;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_char(hex_char, last_char, want, made);
        if (row_typed) deframe_q.push_back(row_want);
        else if (made) deframe_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{data_byte, byte_valid, frame_end, status_e'(frame_status)};
        if (deframe_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, %s %0h valid %b end %b status %0d",
                   $time, "actual byte", got.data, got.has_byte, got.ends, got.status);
        end else begin
          want = deframe_q.pop_front();
          report_field("data_byte", want.data, got.data);
          report_field("byte_valid", 8'(want.has_byte), 8'(got.has_byte));
          report_field("frame_end", 8'(want.ends), 8'(got.ends));
          report_field("frame_status", 8'(want.status), 8'(got.status));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("** hex_frame_deframer_checker: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // present one character and hold it until taken
  task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                           input deframe_res_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    hex_char <= ch;
    last_char <= last;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // let every expected result come out, then a short settle
  task automatic drain();
    in_valid <= 1'b0;
    while (deframe_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_headers(input logic [7:0] first, input logic [7:0] second);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HEADER_FIRST;
    cfg_data <= first;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hdr_first = first;
    @(negedge clk);
    cfg_index <= CFG_HEADER_SECOND;
    cfg_data <= second;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hdr_second = second;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // build the characters of one random frame
  task automatic build_frame();
    frame_shape_e shape;
    int           roll;
    int           n;
    int           k;
    logic [7:0]   body[$];
    logic [7:0]   sum;
    logic [7:0]   c;
    frame_chars.delete();
    roll = $urandom_range(0, 99);
    if (roll < 60) shape = SHAPE_GOOD;
    else if (roll < 64) shape = SHAPE_HEADER;
    else if (roll < 68) shape = SHAPE_LENGTH;
    else if (roll < 72) shape = SHAPE_CHECKSUM;
    else if (roll < 78) shape = SHAPE_BAD_CHAR;
    else if (roll < 83) shape = SHAPE_ODD_TAIL;
    else if (roll < 88) shape = SHAPE_SHORT;
    else if (roll < 94) shape = SHAPE_NOISE;
    else if (roll < 97) shape = SHAPE_FULL;
    else shape = SHAPE_OVERSIZE;
    case (shape)
      SHAPE_SHORT:    n = $urandom_range(0, MinFrame - 1);
      SHAPE_NOISE:    n = 0;
      SHAPE_FULL:     n = MaxFrame;
      SHAPE_OVERSIZE: n = $urandom_range(MaxFrame + 1, MaxFrame + 12);
      default:        n = $urandom_range(MinFrame, 3 * MinFrame);
    endcase
    // header, length, payload and trailing sum
    sum = 8'd0;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1 && i >= 3) c = sum;
      else if (i == 0) c = hdr_first;
      else if (i == 1) c = hdr_second;
      else if (i == 2) c = 8'(n - MinFrame);
      else c = 8'($urandom_range(0, 255));
      sum = sum + c;
      body.push_back(c);
    end
    case (shape)
      SHAPE_HEADER: begin
        k = $urandom_range(0, 1);
        body[k] = body[k] ^ 8'($urandom_range(1, 255));
      end
      SHAPE_LENGTH:   body[2] = body[2] + 8'($urandom_range(1, 255));
      SHAPE_CHECKSUM: body[n - 1] = body[n - 1] + 8'($urandom_range(1, 255));
      default: ;
    endcase
    foreach (body[i]) begin
      frame_chars.push_back(digit_char(body[i][7:4]));
      frame_chars.push_back(digit_char(body[i][3:0]));
    end
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 24)) frame_chars.push_back(8'($urandom_range(0, 255)));
    end
    // one character outside the hex set somewhere in the frame
    if (shape == SHAPE_BAD_CHAR) begin
      do begin
        c = 8'($urandom_range(0, 255));
      end while (hex_value(c) < 5'd16);
      k = $urandom_range(0, frame_chars.size() - 1);
      frame_chars[k] = c;
    end
    if (shape == SHAPE_ODD_TAIL || frame_chars.size() == 0) begin
      frame_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // main sequence
  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    hex_char = 8'h00;
    last_char = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HEADER_FIRST;
    cfg_data = 8'h00;
    row_typed = 1'b0;
    row_want = NoResult;
    char_rows = '{
      // good frame with default header, mixed case, zero and full bytes
      '{"5", 1'b0, 1'b0, NoResult},
      '{"4", 1'b0, 1'b1, '{8'h54, 1'b1, 1'b0, ST_OK}},
      '{"4", 1'b0, 1'b0, NoResult},
      '{"7", 1'b0, 1'b0, NoResult},
      '{"0", 1'b0, 1'b0, NoResult},
      '{"0", 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ST_OK}},
      '{"a", 1'b0, 1'b0, NoResult},
      '{"F", 1'b0, 1'b0, NoResult},
      '{"F", 1'b0, 1'b0, NoResult},
      '{"f", 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, ST_OK}},
      '{"0", 1'b0, 1'b0, NoResult},
      '{"9", 1'b0, 1'b0, NoResult},
      '{"0", 1'b0, 1'b0, NoResult},
      '{"0", 1'b0, 1'b0, NoResult},
      '{"5", 1'b0, 1'b0, NoResult},
      '{"2", 1'b1, 1'b0, NoResult},
      // character extremes, both outside the hex set
      '{8'h00, 1'b0, 1'b0, NoResult},
      '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_HEX}},
      // odd trailing character after one byte
      '{"1", 1'b0, 1'b0, NoResult},
      '{"2", 1'b0, 1'b1, '{8'h12, 1'b1, 1'b0, ST_OK}},
      '{"3", 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_SHORT}},
      // empty frame whose lone character is not hex
      '{"g", 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_SHORT}},
      // character just above the digits
      '{":", 1'b0, 1'b0, NoResult},
      '{"0", 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_HEX}}
    };
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows with reset header values
    idle_on = 1'b1;
    foreach (char_rows[i]) begin
      send_char(char_rows[i].ch, char_rows[i].last, char_rows[i].typed, char_rows[i].want);
    end
    drain();

    // random frames under several header settings, last phase without idling
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_headers(8'h00, 8'hFF);
        1: write_headers(8'hFF, 8'h00);
        2, 3: write_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: write_headers(HeaderFirstRst, HeaderSecondRst);
      endcase
      sent = 0;
      while (sent < PhaseChars) begin
        build_frame();
        idle_on = (phase != 4) && ($urandom_range(0, 3) != 0);
        foreach (frame_chars[k]) begin
          send_char(frame_chars[k], k == frame_chars.size() - 1, 1'b0, NoResult);
        end
        sent += frame_chars.size();
      end
      idle_on = 1'b0;
      drain();
    end

    repeat (4) @(negedge clk);
    if (mismatches == 0 && deframe_q.size() == 0) begin
      $display("** hex_frame_deframer_checker: PASSED **");
    end else begin
      $display("** hex_frame_deframer_checker: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/hfdc_pkg.sv
design/hex_frame_deframer_checker.sv
test/testbench.sv
